### src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### src/jcrd_pkg.sv
// Types, constants and helper functions for the JPEG coefficient run decoder.
package jcrd_pkg;

   localparam logic       MODE_SYMBOL  = 1'b0;
   localparam logic       MODE_RESTART = 1'b1;
   localparam logic [7:0] SYM_EOB      = 8'h00;
   localparam logic [7:0] SYM_ZRL      = 8'hF0;
   localparam logic [3:0] SIZE_MAX     = 4'hF;
   localparam logic [6:0] BLOCK_LEN    = 7'd64;
   localparam logic [6:0] ZRL_SKIP     = 7'd16;
   localparam logic [6:0] LAST_POS     = 7'd63;

   typedef struct packed {
      logic        mode;
      logic [1:0]  component;
      logic [7:0]  symbol;
      logic [14:0] magnitude_bits;
   } req_item_type;

   typedef struct packed {
      logic               write_valid;
      logic [5:0]         coeff_index;
      logic signed [15:0] coeff_value;
      logic               block_done;
   } rsp_item_type;

   // zigzag position -> natural (row-major) position
   localparam logic [5:0] ZZ_TO_NAT [64] = '{
       6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
       6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
       6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
       6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
       6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
       6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
       6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
       6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   // JPEG EXTEND: low 'size' bits as a signed value. Top bit clear means negative,
   // value - (2^size - 1).
   function automatic logic [15:0] extend_bits(input logic [14:0] bits,
                                               input logic [3:0]  size);
      logic [15:0] mask;
      logic [15:0] half;
      logic [15:0] v;
      mask = 16'((17'd1 << size) - 17'd1);
      half = 16'(17'd1 << (size - 4'd1));
      v    = {1'b0, bits} & mask;
      if (size == 4'd0) begin
         return 16'd0;
      end
      if ((v & half) != 16'd0) begin
         return v;
      end
      return v - mask;
   endfunction

endpackage

### src/jcrd_channels.sv
// Valid/ready channel interfaces for symbol requests and coefficient responses.
interface jcrd_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [1:0]  component;
   logic [7:0]  symbol;
   logic [14:0] magnitude_bits;

   modport source (output valid, output mode, output component, output symbol,
                   output magnitude_bits, input ready);
   modport sink   (input valid, input mode, input component, input symbol,
                   input magnitude_bits, output ready);
endinterface

interface jcrd_rsp_if;
   logic               valid;
   logic               ready;
   logic               write_valid;
   logic [5:0]         coeff_index;
   logic signed [15:0] coeff_value;
   logic               block_done;

   modport source (output valid, output write_valid, output coeff_index,
                   output coeff_value, output block_done, input ready);
   modport sink   (input valid, input write_valid, input coeff_index,
                   input coeff_value, input block_done, output ready);
endinterface

### src/jcrd_in_reg.sv
// Input register stage: captures one symbol transfer per cycle unless the core stalls.
`include "assert_macros.svh"

module jcrd_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   jcrd_req_if.sink              req_chan,
   output logic                  out_valid,
   output jcrd_pkg::req_item_type out_item,
   input  logic                  out_ready
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   jcrd_pkg::req_item_type in_item_ff;
   logic                   req_take;

   assign req_chan.ready = !in_valid_ff || out_ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (out_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode           <= req_chan.mode;
         in_item_ff.component      <= req_chan.component;
         in_item_ff.symbol         <= req_chan.symbol;
         in_item_ff.magnitude_bits <= req_chan.magnitude_bits;
      end
   end

   assign out_valid = in_valid_ff;
   assign out_item  = in_item_ff;

   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !in_valid_ff, "input stage valid after reset")
   `ASSERT_RST(a_take_fills, clock, reset, req_take |=> in_valid_ff, "accepted symbol lost")
   `ASSERT_RST(a_stall_holds, clock, reset, (in_valid_ff && !out_ready) |=> (in_valid_ff && $stable(in_item_ff)), "stalled symbol changed")

endmodule

### src/jcrd_core.sv
// Decode logic, DC predictors, zigzag position and result register.
`include "assert_macros.svh"

module jcrd_core #(
   parameter int COMP_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  jcrd_pkg::req_item_type in_item,
   output logic                   in_ready,
   jcrd_rsp_if.source             rsp_chan
);

   localparam int CIDX_W = (COMP_COUNT > 1) ? $clog2(COMP_COUNT) : 1;
   localparam logic [CIDX_W-1:0] LAST_COMP = CIDX_W'(COMP_COUNT - 1);

   logic [15:0]            dc_pred_ff [COMP_COUNT];
   logic [5:0]             pos_ff;
   logic [5:0]             pos_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   jcrd_pkg::rsp_item_type rsp_item_ff;
   jcrd_pkg::rsp_item_type rsp_item_in;

   logic              advance;
   logic [CIDX_W-1:0] comp_sel;
   logic [3:0]        dc_size;
   logic [15:0]       dc_sum;
   logic [6:0]        k_run;
   logic [6:0]        k_zrl;
   logic              pred_we;
   logic              pred_clear;

   assign in_ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid && in_ready;

   always_comb begin
      if (32'(in_item.component) >= COMP_COUNT) begin
         comp_sel = LAST_COMP;
      end else begin
         comp_sel = CIDX_W'(in_item.component);
      end
      dc_size = (in_item.symbol > 8'(jcrd_pkg::SIZE_MAX)) ? jcrd_pkg::SIZE_MAX
                                                         : in_item.symbol[3:0];
      dc_sum  = dc_pred_ff[comp_sel] + jcrd_pkg::extend_bits(in_item.magnitude_bits, dc_size);
      k_run   = {1'b0, pos_ff} + {3'b000, in_item.symbol[7:4]};
      k_zrl   = {1'b0, pos_ff} + jcrd_pkg::ZRL_SKIP;
   end

   always_comb begin
      rsp_item_in = '0;
      pos_in      = pos_ff;
      pred_we     = 1'b0;
      pred_clear  = 1'b0;
      if (in_item.mode == jcrd_pkg::MODE_RESTART) begin
         pred_clear = 1'b1;
         pos_in     = 6'd0;
      end else if (pos_ff == 6'd0) begin
         // DC term
         pred_we                 = 1'b1;
         rsp_item_in.write_valid = 1'b1;
         rsp_item_in.coeff_value = dc_sum;
         pos_in                  = 6'd1;
      end else if (in_item.symbol == jcrd_pkg::SYM_EOB) begin
         rsp_item_in.block_done = 1'b1;
         pos_in                 = 6'd0;
      end else if (in_item.symbol == jcrd_pkg::SYM_ZRL) begin
         if (k_zrl >= jcrd_pkg::BLOCK_LEN) begin
            rsp_item_in.block_done = 1'b1;
            pos_in                 = 6'd0;
         end else begin
            pos_in = k_zrl[5:0];
         end
      end else if (k_run >= jcrd_pkg::BLOCK_LEN) begin
         // run past the end: block closes with no write
         rsp_item_in.block_done = 1'b1;
         pos_in                 = 6'd0;
      end else begin
         rsp_item_in.write_valid = 1'b1;
         rsp_item_in.coeff_index = jcrd_pkg::ZZ_TO_NAT[k_run[5:0]];
         rsp_item_in.coeff_value = jcrd_pkg::extend_bits(in_item.magnitude_bits,
                                                         in_item.symbol[3:0]);
         if (k_run == jcrd_pkg::LAST_POS) begin
            rsp_item_in.block_done = 1'b1;
            pos_in                 = 6'd0;
         end else begin
            pos_in = 6'(k_run + 7'd1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 6'd0;
         for (int i = 0; i < COMP_COUNT; i++) begin
            dc_pred_ff[i] <= 16'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
            if (pred_clear) begin
               for (int i = 0; i < COMP_COUNT; i++) begin
                  dc_pred_ff[i] <= 16'd0;
               end
            end else if (pred_we) begin
               dc_pred_ff[comp_sel] <= dc_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.write_valid = rsp_item_ff.write_valid;
   assign rsp_chan.coeff_index = rsp_item_ff.coeff_index;
   assign rsp_chan.coeff_value = rsp_item_ff.coeff_value;
   assign rsp_chan.block_done  = rsp_item_ff.block_done;

   `ASSERT_RST(a_dc_at_zero, clock, reset,
      (advance && (in_item.mode == jcrd_pkg::MODE_SYMBOL) && (pos_ff == 6'd0)) |=>
      (rsp_valid_ff && rsp_item_ff.write_valid && (rsp_item_ff.coeff_index == 6'd0)),
      "DC term not written at index zero")
   `ASSERT_RST(a_no_write_zero, clock, reset,
      (rsp_valid_ff && !rsp_item_ff.write_valid) |->
      ((rsp_item_ff.coeff_index == 6'd0) && (rsp_item_ff.coeff_value == 16'sd0)),
      "nonzero payload without write")
   `ASSERT_RST(a_restart_clears, clock, reset,
      (advance && (in_item.mode == jcrd_pkg::MODE_RESTART)) |=>
      ((pos_ff == 6'd0) && (dc_pred_ff[0] == 16'd0) && !rsp_item_ff.write_valid &&
       !rsp_item_ff.block_done),
      "restart did not clear state")

endmodule

### src/jpeg_coefficient_run_decoder_top.sv
// Top level of the JPEG baseline run-length coefficient decoder.
// Path: a req transfer is captured in the input register, then in the result register, before it goes out on rsp.
// Throughput: one symbol per cycle while rsp does not stall; exactly one rsp transfer per req transfer.
// Backpressure: while a result waits on rsp, req takes at most one more symbol, then stalls.
// Reset (synchronous, active high): clears DC predictors, zigzag position and both valids.
// No clearing pass: the block accepts symbols in the first cycle after reset.

module jpeg_coefficient_run_decoder_top #(
   parameter int COMP_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   jcrd_req_if.sink    req_chan,
   jcrd_rsp_if.source  rsp_chan
);

   // Registered symbol handed from the input stage to the decode core.
   logic                   sym_valid;
   logic                   sym_ready;
   jcrd_pkg::req_item_type sym_item;

   // Input stage: one transfer per cycle, stalls only when the core stalls.
   jcrd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (sym_valid),
      .out_item  (sym_item),
      .out_ready (sym_ready)
   );

   // Decode core: EXTEND, DC prediction, run/ZRL/EOB handling, de-zigzag lookup,
   // and the result register driving rsp.
   jcrd_core #(
      .COMP_COUNT (COMP_COUNT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sym_valid),
      .in_item  (sym_item),
      .in_ready (sym_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

### dv/tb_jpeg_coefficient_run_decoder_top.sv
// Self-checking testbench for the JPEG run-length coefficient decoder top level.
`timescale 1ns / 100ps

module tb_jpeg_coefficient_run_decoder_top;

   localparam int COMPONENTS     = 4;
   localparam int RANDOM_SYMBOLS = 700;
   localparam int STEADY_SYMBOLS = 150;   // opening stretch of the random part, no idling
   localparam int HOLD_OFF_AT    = 400;   // random symbol count that triggers the long stall
   localparam int HOLD_OFF_LEN   = 300;   // cycles the receiver holds ready low
   localparam int DRAIN_CYCLES   = 8;     // pipeline is 2 deep; a few spare edges
   localparam int CYCLE_LIMIT    = 200000;

   // One row of the directed table: a symbol and, where it is obvious, the
   // coefficient write it must produce. Other rows rely on the predictor.
   typedef struct {
      jcrd_pkg::req_item_type symbol_in;
      bit                     fixed_result;
      jcrd_pkg::rsp_item_type result;
   } plan_row_type;

   logic clock;
   logic reset;

   jcrd_req_if req_bus ();
   jcrd_rsp_if rsp_bus ();

   jpeg_coefficient_run_decoder_top #(
      .COMP_COUNT(COMPONENTS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus.sink),
      .rsp_chan(rsp_bus.source)
   );

   // Predictor state: DC predictor per component, position inside the block
   // (0 means the next symbol is DC), and our own zigzag-to-natural map.
   logic [15:0]  dc_history [COMPONENTS];
   logic [6:0]   block_position;
   logic [5:0]   zigzag_map [64];

   jcrd_pkg::rsp_item_type pending_coeffs [$];
   plan_row_type           directed_plan [$];

   // Side-band that travels with the payload so the monitor knows whether the
   // current transfer carries a typed-in result.
   bit                     row_fixed;
   jcrd_pkg::rsp_item_type row_result;

   bit           steady_phase;
   bit           hold_off_req;
   int           mismatch_count;
   int           symbols_sent;
   int           cycle_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Zigzag order built by walking the anti-diagonals of the 8x8 block:
   // even diagonals go up and to the right, odd ones down and to the left.
   initial begin
      int pos;
      int row;
      pos = 0;
      for (int diag = 0; diag < 15; diag++) begin
         if (diag % 2 == 0) begin
            for (row = (diag < 8 ? diag : 7); row >= (diag > 7 ? diag - 7 : 0); row--) begin
               zigzag_map[pos] = 6'(row * 8 + diag - row);
               pos++;
            end
         end else begin
            for (row = (diag > 7 ? diag - 7 : 0); row <= (diag < 8 ? diag : 7); row++) begin
               zigzag_map[pos] = 6'(row * 8 + diag - row);
               pos++;
            end
         end
      end
   end

   // JPEG EXTEND: low nbits of raw; a clear top bit means raw - (2^nbits - 1).
   function automatic logic [15:0] magnitude_value(logic [14:0] raw, int nbits);
      int span;
      int field_v;
      if (nbits == 0) return 16'd0;
      span    = (1 << nbits) - 1;
      field_v = int'(raw) & span;
      if (((field_v >> (nbits - 1)) & 1) != 0) return 16'(field_v);
      return 16'(field_v - span);
   endfunction

   // Predictor: one decoded symbol in, the coefficient write it causes out.
   function automatic jcrd_pkg::rsp_item_type decode_symbol(jcrd_pkg::req_item_type sym_in);
      jcrd_pkg::rsp_item_type res;
      int                     comp;
      int                     k;
      int                     dc_size;
      res  = '0;
      comp = (int'(sym_in.component) >= COMPONENTS) ? COMPONENTS - 1 : int'(sym_in.component);
      if (sym_in.mode == jcrd_pkg::MODE_RESTART) begin
         for (int c = 0; c < COMPONENTS; c++) dc_history[c] = 16'd0;
         block_position = 7'd0;
      end else if (block_position == 7'd0) begin
         // DC: size clamps to 15, sum wraps at 16 bits
         dc_size = (sym_in.symbol > jcrd_pkg::SIZE_MAX) ? int'(jcrd_pkg::SIZE_MAX)
                                                       : int'(sym_in.symbol);
         dc_history[comp] = dc_history[comp]
                          + magnitude_value(sym_in.magnitude_bits, dc_size);
         res.write_valid = 1'b1;
         res.coeff_value = dc_history[comp];
         block_position  = 7'd1;
      end else if (sym_in.symbol == jcrd_pkg::SYM_EOB) begin
         res.block_done = 1'b1;
         block_position = 7'd0;
      end else begin
         k = int'(block_position);
         if (sym_in.symbol == jcrd_pkg::SYM_ZRL) k += int'(jcrd_pkg::ZRL_SKIP);
         else                                    k += int'(sym_in.symbol[7:4]);
         if (k >= int'(jcrd_pkg::BLOCK_LEN)) begin
            // run falls off the end of the block: no write
            res.block_done = 1'b1;
            block_position = 7'd0;
         end else if (sym_in.symbol == jcrd_pkg::SYM_ZRL) begin
            block_position = 7'(k);
         end else begin
            res.write_valid = 1'b1;
            res.coeff_index = zigzag_map[k];
            res.coeff_value = magnitude_value(sym_in.magnitude_bits, int'(sym_in.symbol[3:0]));
            k++;
            if (k >= int'(jcrd_pkg::BLOCK_LEN)) begin
               res.block_done = 1'b1;
               block_position = 7'd0;
            end else begin
               block_position = 7'(k);
            end
         end
      end
      return res;
   endfunction

   function automatic jcrd_pkg::req_item_type make_symbol(logic mode, logic [1:0] comp,
                                                          logic [7:0] sym, logic [14:0] raw);
      jcrd_pkg::req_item_type s;
      s.mode           = mode;
      s.component      = comp;
      s.symbol         = sym;
      s.magnitude_bits = raw;
      return s;
   endfunction

   function automatic jcrd_pkg::rsp_item_type make_coeff(logic wv, logic [5:0] idx,
                                                         logic [15:0] val, logic done);
      jcrd_pkg::rsp_item_type r;
      r.write_valid = wv;
      r.coeff_index = idx;
      r.coeff_value = val;
      r.block_done  = done;
      return r;
   endfunction

   function automatic void plan_checked(jcrd_pkg::req_item_type s, jcrd_pkg::rsp_item_type r);
      directed_plan.push_back('{symbol_in: s, fixed_result: 1'b1, result: r});
   endfunction

   function automatic void plan_predicted(jcrd_pkg::req_item_type s);
      directed_plan.push_back('{symbol_in: s, fixed_result: 1'b0, result: '0});
   endfunction

   // Offer one symbol and hold it until the transfer happens. Random idle
   // cycles go in front of it outside the steady stretch.
   task automatic send_symbol(jcrd_pkg::req_item_type s, bit fixed, jcrd_pkg::rsp_item_type r);
      while (!steady_phase && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      {req_bus.mode, req_bus.component, req_bus.symbol, req_bus.magnitude_bits} <= s;
      row_fixed  <= fixed;
      row_result <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      symbols_sent++;
   endtask

   // One well-formed block with random content: DC, then AC symbols until an
   // EOB or until the run reaches the end. Now and then a restart cuts it short.
   task automatic send_block();
      int          pos;
      int          pick;
      int          run;
      int          size;
      logic [7:0]  dc_sym;
      logic [7:0]  ac_sym;
      dc_sym = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255));
      send_symbol(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'($urandom_range(0, 3)), dc_sym,
                              15'($urandom)), 1'b0, '0);
      pos = 1;
      while (pos < 64) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            send_symbol(make_symbol(jcrd_pkg::MODE_RESTART, 2'($urandom), 8'($urandom),
                                    15'($urandom)), 1'b0, '0);
            pos = 64;
         end else if (pick < 12) begin
            send_symbol(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'($urandom), jcrd_pkg::SYM_EOB,
                                    15'($urandom)), 1'b0, '0);
            pos = 64;
         end else if (pick < 20) begin
            send_symbol(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'($urandom), jcrd_pkg::SYM_ZRL,
                                    15'($urandom)), 1'b0, '0);
            pos += 16;
         end else begin
            run  = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            size = ($urandom_range(99) < 80) ? $urandom_range(1, 10) : $urandom_range(0, 15);
            ac_sym = {4'(run), 4'(size)};
            send_symbol(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'($urandom), ac_sym, 15'($urandom)),
                        1'b0, '0);
            pos += run + 1;
         end
      end
   endtask

   // Monitor and scoreboard. Both handshakes are sampled at the rising edge;
   // the response check runs first, so a same-edge request never feeds it.
   always @(posedge clock) begin : transfer_check
      jcrd_pkg::req_item_type seen;
      jcrd_pkg::rsp_item_type predicted;
      jcrd_pkg::rsp_item_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_coeffs.size() == 0) begin
               $error("coefficient transfer with nothing expected");
               mismatch_count++;
            end else begin
               want = pending_coeffs.pop_front();
               if (rsp_bus.write_valid !== want.write_valid) begin
                  $error("write_valid: expected %0b, got %0b", want.write_valid,
                         rsp_bus.write_valid);
                  mismatch_count++;
               end
               if (rsp_bus.coeff_index !== want.coeff_index) begin
                  $error("coeff_index: expected %0d, got %0d", want.coeff_index,
                         rsp_bus.coeff_index);
                  mismatch_count++;
               end
               if (rsp_bus.coeff_value !== want.coeff_value) begin
                  $error("coeff_value: expected %0d, got %0d", want.coeff_value,
                         rsp_bus.coeff_value);
                  mismatch_count++;
               end
               if (rsp_bus.block_done !== want.block_done) begin
                  $error("block_done: expected %0b, got %0b", want.block_done,
                         rsp_bus.block_done);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen = make_symbol(req_bus.mode, req_bus.component, req_bus.symbol,
                               req_bus.magnitude_bits);
            // predictor always advances so its state tracks the block
            predicted = decode_symbol(seen);
            pending_coeffs.push_back(row_fixed ? row_result : predicted);
         end
      end
   end

   // Receiver: random stalls, none in the steady stretch, and one long
   // hold-off on request so the block backs up into its input.
   initial begin
      forever begin
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_bus.ready <= steady_phase || ($urandom_range(99) >= 15);
         end
         @(posedge clock);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus: reset, directed table, random blocks, drain, verdict.
   initial begin
      int       random_start;
      int       pick;
      bit       pressure_done;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      {req_bus.mode, req_bus.component, req_bus.symbol, req_bus.magnitude_bits} <= '0;
      row_fixed      <= 1'b0;
      row_result     <= '0;
      steady_phase   = 1'b0;
      hold_off_req   = 1'b0;
      pressure_done  = 1'b0;
      mismatch_count = 0;
      symbols_sent   = 0;
      cycle_count    = 0;
      for (int c = 0; c < COMPONENTS; c++) dc_history[c] = 16'd0;
      block_position = 7'd0;

      // Directed rows.
      // DC of size zero right after reset, then EOB
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd0, 8'h00, 15'h0000),
                   make_coeff(1'b1, 6'd0, 16'd0, 1'b0));
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd0, jcrd_pkg::SYM_EOB, 15'h0000),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b1));
      // largest positive DC, then most negative AC at position 1
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'h0F, 15'h7FFF),
                   make_coeff(1'b1, 6'd0, 16'h7FFF, 1'b0));
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'h0F, 15'h0000),
                   make_coeff(1'b1, 6'd1, 16'h8001, 1'b0));
      // ZRL to 18, long run, ZRL to 50, ZRL past the end
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, jcrd_pkg::SYM_ZRL, 15'h7FFF),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b0));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'hF1, 15'h0001));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, jcrd_pkg::SYM_ZRL, 15'h0000));
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, jcrd_pkg::SYM_ZRL, 15'h0000),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b1));
      // oversized DC size clamps to 15; predictor wraps back to zero
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'hFF, 15'h0000));
      // runs that land exactly on the last coefficient
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'hE1, 15'h0000));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'hF5, 15'h001F));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'hF5, 15'h0015));
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd1, 8'hF5, 15'h0010),
                   make_coeff(1'b1, 6'd63, 16'd16, 1'b1));
      // restart with junk in the other fields
      plan_checked(make_symbol(jcrd_pkg::MODE_RESTART, 2'd2, 8'hA5, 15'h5555),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b0));
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, 8'h01, 15'h0000),
                   make_coeff(1'b1, 6'd0, 16'hFFFF, 1'b0));
      // AC of size zero still skips its run and writes zero
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, 8'h30, 15'h7FFF));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, jcrd_pkg::SYM_ZRL, 15'h0000));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, jcrd_pkg::SYM_ZRL, 15'h0000));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, jcrd_pkg::SYM_ZRL, 15'h0000));
      // run of 11 from 53 reaches 64: ends the block with no write
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, 8'hB3, 15'h0000),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b1));
      // zero-size DC on all-ones bits, then a restart in the middle of a block
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd2, 8'h00, 15'h7FFF));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd2, 8'h01, 15'h0001));
      plan_checked(make_symbol(jcrd_pkg::MODE_RESTART, 2'd0, 8'h00, 15'h0000),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b0));
      plan_predicted(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, 8'h0E, 15'h2000));
      plan_checked(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'd3, jcrd_pkg::SYM_EOB, 15'h7FFF),
                   make_coeff(1'b0, 6'd0, 16'd0, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         send_symbol(directed_plan[i].symbol_in, directed_plan[i].fixed_result,
                     directed_plan[i].result);

      // Random part: mostly well-formed blocks, some stray restarts and
      // arbitrary symbols. Opens with a stretch where neither side idles.
      random_start = symbols_sent;
      steady_phase = 1'b1;
      while (symbols_sent - random_start < RANDOM_SYMBOLS) begin
         if (symbols_sent - random_start >= STEADY_SYMBOLS) steady_phase = 1'b0;
         if (!pressure_done && symbols_sent - random_start >= HOLD_OFF_AT) begin
            hold_off_req  = 1'b1;
            pressure_done = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 4)
            send_symbol(make_symbol(jcrd_pkg::MODE_RESTART, 2'($urandom), 8'($urandom),
                                    15'($urandom)), 1'b0, '0);
         else if (pick < 10)
            send_symbol(make_symbol(jcrd_pkg::MODE_SYMBOL, 2'($urandom), 8'($urandom),
                                    15'($urandom)), 1'b0, '0);
         else
            send_block();
      end
      steady_phase  = 1'b0;
      req_bus.valid <= 1'b0;

      // drain, then give the pipeline a few more edges to show stray output
      while (pending_coeffs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_coeffs.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/jcrd_pkg.sv
src/jcrd_channels.sv
src/jcrd_in_reg.sv
src/jcrd_core.sv
src/jpeg_coefficient_run_decoder_top.sv
dv/tb_jpeg_coefficient_run_decoder_top.sv
